@@ rtl/core/rsna_pkg.sv @@
// Shared types, constants and helper functions of the RDS station name assembler.
package rsna_pkg;

    // Name geometry and field widths.
    localparam int NAME_LEN  = 8;
    localparam int CHAR_W    = 8;
    localparam int SEG_W     = 2;
    localparam int GTYPE_W   = 4;
    localparam int NAME_W    = NAME_LEN * CHAR_W;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = GTYPE_W;
    localparam int M_TDATA_W = 72;

    // Group type that carries the program service name.
    localparam logic [GTYPE_W-1:0] GROUP_TYPE_PS = 4'd0;

    // Character codes used by the name check.
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;

    typedef logic [CHAR_W-1:0] char_t;

    // Write request from the top level to one lane.
    typedef struct packed {
        logic  wr;
        char_t chr;
    } lane_in_t;

    // Updated stable character of one lane and its check flag.
    typedef struct packed {
        char_t chr;
        logic  ok;
    } lane_out_t;

    // A character is displayable when it is a capital letter or a space.
    function automatic logic char_ok(input char_t c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) || (c == CHAR_SPACE);
    endfunction

endpackage

@@ rtl/core/rsna_lane.sv @@
// One character position: pending and stable character with promote-on-match logic.
module rsna_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsna_pkg::lane_in_t  lane_in,
    output rsna_pkg::lane_out_t lane_out
);
    import rsna_pkg::*;

    char_t pending_reg, pending_next;
    char_t stable_reg, stable_next;
    logic  hit;

    // A received character equal to the pending one is promoted to stable;
    // otherwise it becomes the new pending character.
    always_comb begin
        hit          = lane_in.wr && (pending_reg == lane_in.chr);
        stable_next  = hit ? lane_in.chr : stable_reg;
        pending_next = (lane_in.wr && !hit) ? lane_in.chr : pending_reg;
    end

    // Both characters start out as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            stable_reg  <= '0;
        end else begin
            pending_reg <= pending_next;
            stable_reg  <= stable_next;
        end
    end

    // The merge stage sees the value this item leaves behind.
    assign lane_out.chr = stable_next;
    assign lane_out.ok  = char_ok(stable_next);

endmodule

@@ rtl/core/rsna_merge.sv @@
// Merge stage: joins the lane characters into the name and holds the result item.
module rsna_merge (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [rsna_pkg::SEG_W-1:0]  seg,
    input  rsna_pkg::lane_out_t         lanes [rsna_pkg::NAME_LEN],
    input  logic                        m_tready,
    output logic                        m_tvalid,
    // Fields from bit 0 up: stable_name[63:0], name_ok[64], segment_done[66:65], zero pad.
    output logic [rsna_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsna_pkg::*;

    logic [NAME_W-1:0] name_comb;
    logic              ok_comb;
    logic [NAME_W-1:0] name_reg;
    logic              ok_reg;
    logic [SEG_W-1:0]  seg_reg;
    logic              valid_reg, valid_next;

    // Character zero goes to the top byte; the name is fine only if every lane agrees.
    always_comb begin
        ok_comb = 1'b1;
        for (int i = 0; i < NAME_LEN; i++) begin
            name_comb[NAME_W-1-CHAR_W*i -: CHAR_W] = lanes[i].chr;
            ok_comb = ok_comb & lanes[i].ok;
        end
    end

    // Output register: a new item loads it, a taken item empties it.
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            name_reg <= name_comb;
            ok_reg   <= ok_comb;
            seg_reg  <= seg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(M_TDATA_W-NAME_W-1-SEG_W){1'b0}}, seg_reg, ok_reg, name_reg};

endmodule

@@ rtl/core/rds_station_name_assembler.sv @@
// Top level of the RDS station name assembler: input decode, eight lanes and the merge stage.
//
//  Channel | Direction | Ports                              | Item
//  s_      | in        | s_tvalid s_tready s_tdata s_tuser  | one decoded RDS group
//  m_      | out       | m_tvalid m_tready m_tdata          | stable name after a type-0 group
//
// For a type-0 group the lanes update and the merge register loads at the accepting
// edge, so the result shows in the cycle after acceptance; a new item can be accepted
// every cycle while the output is not stalled. Synchronous active-low reset clears all
// pending and stable characters and empties the output register. Input is accepted
// whenever the output register is empty or is being taken in the same cycle; a stalled
// result holds the input off. Groups of other types are accepted and dropped.
module rds_station_name_assembler (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // Fields from bit 0 up: segment_address[1:0], first_char[9:2], second_char[17:10],
    // zero pad.
    input  logic [rsna_pkg::S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0 up: group_type[3:0].
    input  logic [rsna_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // Fields from bit 0 up: stable_name[63:0], name_ok[64], segment_done[66:65], zero pad.
    output logic [rsna_pkg::M_TDATA_W-1:0] m_tdata
);
    import rsna_pkg::*;

    logic             accept;
    logic             use_group;
    logic [SEG_W-1:0] seg;
    char_t            first_char;
    char_t            second_char;
    lane_in_t         lane_in  [NAME_LEN];
    lane_out_t        lane_out [NAME_LEN];

    // Input decode.
    assign s_tready    = !m_tvalid || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign use_group   = accept && (s_tuser == GROUP_TYPE_PS);
    assign seg         = s_tdata[SEG_W-1:0];
    assign first_char  = s_tdata[SEG_W+CHAR_W-1:SEG_W];
    assign second_char = s_tdata[SEG_W+2*CHAR_W-1:SEG_W+CHAR_W];

    // One lane per character position; a segment addresses an even/odd pair.
    for (genvar i = 0; i < NAME_LEN; i++) begin : g_lane
        assign lane_in[i].wr  = use_group && (seg == SEG_W'(i / 2));
        assign lane_in[i].chr = (i % 2 == 0) ? first_char : second_char;

        rsna_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .lane_in  (lane_in[i]),
            .lane_out (lane_out[i])
        );
    end

    rsna_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (use_group),
        .seg      (seg),
        .lanes    (lane_out),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // A used group shows up as a result carrying its segment address.
    a_used_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        use_group |=> (m_tvalid && (m_tdata[NAME_W+SEG_W:NAME_W+1] == $past(seg))))
        else $error("used group did not produce its result");

    // A dropped group never creates a result out of an empty output register.
    a_dropped_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !use_group) |=> !m_tvalid)
        else $error("result appeared without a used group");

    // The name flag agrees with the characters it summarizes.
    a_name_ok_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[NAME_W] == (char_ok(m_tdata[63:56]) && char_ok(m_tdata[55:48])
            && char_ok(m_tdata[47:40]) && char_ok(m_tdata[39:32])
            && char_ok(m_tdata[31:24]) && char_ok(m_tdata[23:16])
            && char_ok(m_tdata[15:8]) && char_ok(m_tdata[7:0]))))
        else $error("name_ok disagrees with stable name");

    // Only the lanes of the addressed segment may be written.
    a_lane_pair_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({lane_in[7].wr, lane_in[6].wr, lane_in[5].wr, lane_in[4].wr,
                    lane_in[3].wr, lane_in[2].wr, lane_in[1].wr, lane_in[0].wr})
            == (use_group ? 2 : 0))
        else $error("wrong number of lanes written");
`endif

endmodule
